/* rtl/chs_pkg.sv */
// Shared constants, codes, types and the default link function of the chained hash set unit.
package chs_pkg;

    localparam int CAPACITY    = 32;
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int PTR_W       = IDX_W + 1;
    localparam int COUNT_W     = $clog2(CAPACITY + 1);
    localparam int HASH_BITS   = 32;
    localparam int HANDLE_BITS = 32;
    localparam int OP_W        = 2;
    localparam int STATUS_W    = 2;
    localparam int S_TDATA_W   = ((HASH_BITS + HANDLE_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W   = ((HANDLE_BITS + COUNT_W + 7) / 8) * 8;
    localparam int M_PAD_W     = M_TDATA_W - HANDLE_BITS - COUNT_W;

    // The null pointer is the first index past the pool.
    localparam logic [PTR_W-1:0] NIL_PTR = PTR_W'(CAPACITY);

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_REMOVE = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE    = 2'd0,
        ST_PRESENT = 2'd1,
        ST_ABSENT  = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HEAD,
        S_WALK,
        S_ACT,
        S_ADD_LINK,
        S_REM_FREE,
        S_RESULT
    } state_t;

    // Link of an entry that was never written since reset or clear: the
    // free list runs through the pool in index order.
    function automatic logic [PTR_W-1:0] default_link(input logic [IDX_W-1:0] idx);
        logic [PTR_W-1:0] nxt;
        if (idx == IDX_W'(CAPACITY - 1))
        begin
            nxt = NIL_PTR;
        end
        else
        begin
            nxt = PTR_W'(idx) + PTR_W'(1);
        end
        return nxt;
    endfunction

endpackage

/* rtl/chs_ram.sv */
// Simple dual-port synchronous RAM with one write port and a registered read port.
module chs_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

/* rtl/chained_hash_set_unit.sv */
// Top level of the chained hash set: a fixed pool of entries chained off hashed buckets.
//
// The unit holds up to 32 element handles, each keyed by a 32-bit hash that
// is computed outside. An entry hangs in a singly linked chain off the bucket
// picked by the low five hash bits; unused entries sit on a free list. Two
// elements are the same when their hashes are equal. One beat in gives one
// beat out. A lookup walks the chain from the bucket head, visiting one chain
// entry per cycle, since each step waits on the registered read of the entry
// memories for the next link; add and remove pass through a further state
// (S_ADD_LINK or S_REM_FREE), because the free list pointer and the unlinked
// entry each need their own access to the link memory. Clear goes from
// acceptance straight to the result state. The next beat is accepted once the
// current one has been placed in the output register, so a result may wait for
// the downstream side while the next operation is already under way. Buckets and
// links carry one valid flag per entry, so reset and clear take effect at
// once and no clearing pass through the memories is needed.
module chained_hash_set_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [31:0] key_hash, [63:32] element_value
    input  logic [chs_pkg::S_TDATA_W-1:0] s_tdata,
    // [1:0] operation
    input  logic [chs_pkg::OP_W-1:0]      s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [31:0] found_value, [37:32] entry_count, [39:38] zero
    output logic [chs_pkg::M_TDATA_W-1:0] m_tdata,
    // [1:0] status
    output logic [chs_pkg::STATUS_W-1:0]  m_tuser
);

    import chs_pkg::*;

    // Control state.
    state_t                 state_reg, state_next;
    op_t                    op_reg, op_next;
    logic [PTR_W-1:0]       free_head_reg, free_head_next;
    logic [COUNT_W-1:0]     count_reg, count_next;
    logic [CAPACITY-1:0]    bucket_vld_reg, link_vld_reg;
    logic                   bucket_rvld_reg, link_rvld_reg;
    logic [IDX_W-1:0]       ent_raddr_reg;
    logic                   m_valid_reg;

    // Working registers of the current operation.
    logic [HASH_BITS-1:0]   hash_reg, hash_next;
    logic [HANDLE_BITS-1:0] value_reg, value_next;
    logic [PTR_W-1:0]       cur_reg, cur_next;
    logic [PTR_W-1:0]       prev_reg, prev_next;
    logic [PTR_W-1:0]       head_reg, head_next;
    logic [PTR_W-1:0]       hit_reg, hit_next;
    logic [PTR_W-1:0]       hit_link_reg, hit_link_next;
    logic [HANDLE_BITS-1:0] found_reg, found_next;
    status_t                status_reg, status_next;

    // Output register.
    status_t                m_status_reg;
    logic [HANDLE_BITS-1:0] m_found_reg;
    logic [COUNT_W-1:0]     m_count_reg;

    // Memory ports.
    logic                   bucket_we, link_we, ent_we;
    logic [IDX_W-1:0]       bucket_waddr, link_waddr, bucket_raddr, ent_raddr;
    logic [PTR_W-1:0]       bucket_wdata, link_wdata;
    logic [PTR_W-1:0]       bucket_q, link_q;
    logic [HASH_BITS-1:0]   hash_q;
    logic [HANDLE_BITS-1:0] handle_q;
    logic [PTR_W-1:0]       bucket_rd, link_rd;
    logic [IDX_W-1:0]       bkt_idx;
    logic                   clear_all;
    logic                   out_load;

    assign bkt_idx = hash_reg[IDX_W-1:0];

    // An entry that has not been written since reset or clear reads as its
    // reset value: an empty bucket, or the next entry in index order.
    assign bucket_rd = bucket_rvld_reg ? bucket_q : NIL_PTR;
    assign link_rd   = link_rvld_reg ? link_q : default_link(ent_raddr_reg);

    chs_ram #(.DEPTH(CAPACITY), .WIDTH(PTR_W)) u_bucket_ram (
        .clk   (clk),
        .we    (bucket_we),
        .waddr (bucket_waddr),
        .wdata (bucket_wdata),
        .raddr (bucket_raddr),
        .rdata (bucket_q)
    );

    chs_ram #(.DEPTH(CAPACITY), .WIDTH(PTR_W)) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (ent_raddr),
        .rdata (link_q)
    );

    chs_ram #(.DEPTH(CAPACITY), .WIDTH(HASH_BITS)) u_hash_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (free_head_reg[IDX_W-1:0]),
        .wdata (hash_reg),
        .raddr (ent_raddr),
        .rdata (hash_q)
    );

    chs_ram #(.DEPTH(CAPACITY), .WIDTH(HANDLE_BITS)) u_handle_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (free_head_reg[IDX_W-1:0]),
        .wdata (value_reg),
        .raddr (ent_raddr),
        .rdata (handle_q)
    );

    // The bucket is read as the beat is accepted, so the head is ready in
    // the following cycle.
    assign bucket_raddr = (state_reg == S_IDLE) ? s_tdata[IDX_W-1:0] : bkt_idx;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            op_reg          <= OP_ADD;
            free_head_reg   <= '0;
            count_reg       <= '0;
            bucket_vld_reg  <= '0;
            link_vld_reg    <= '0;
            bucket_rvld_reg <= 1'b0;
            link_rvld_reg   <= 1'b0;
            ent_raddr_reg   <= '0;
            m_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            op_reg          <= op_next;
            free_head_reg   <= free_head_next;
            count_reg       <= count_next;
            bucket_rvld_reg <= bucket_vld_reg[bucket_raddr];
            link_rvld_reg   <= link_vld_reg[ent_raddr];
            ent_raddr_reg   <= ent_raddr;
            if (clear_all)
            begin
                bucket_vld_reg <= '0;
                link_vld_reg   <= '0;
            end
            else
            begin
                if (bucket_we)
                begin
                    bucket_vld_reg[bucket_waddr] <= 1'b1;
                end
                if (link_we)
                begin
                    link_vld_reg[link_waddr] <= 1'b1;
                end
            end
            if (out_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hash_reg     <= hash_next;
        value_reg    <= value_next;
        cur_reg      <= cur_next;
        prev_reg     <= prev_next;
        head_reg     <= head_next;
        hit_reg      <= hit_next;
        hit_link_reg <= hit_link_next;
        found_reg    <= found_next;
        status_reg   <= status_next;
        if (out_load)
        begin
            m_status_reg <= status_reg;
            m_found_reg  <= found_reg;
            m_count_reg  <= count_reg;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        free_head_next = free_head_reg;
        count_next     = count_reg;
        hash_next      = hash_reg;
        value_next     = value_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        head_next      = head_reg;
        hit_next       = hit_reg;
        hit_link_next  = hit_link_reg;
        found_next     = found_reg;
        status_next    = status_reg;
        s_tready       = 1'b0;
        clear_all      = 1'b0;
        out_load       = 1'b0;
        ent_raddr      = ent_raddr_reg;
        bucket_we      = 1'b0;
        bucket_waddr   = bkt_idx;
        bucket_wdata   = NIL_PTR;
        link_we        = 1'b0;
        link_waddr     = hit_reg[IDX_W-1:0];
        link_wdata     = free_head_reg;
        ent_we         = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    op_next    = op_t'(s_tuser);
                    hash_next  = s_tdata[HASH_BITS-1:0];
                    value_next = s_tdata[HASH_BITS +: HANDLE_BITS];
                    if (op_t'(s_tuser) == OP_CLEAR)
                    begin
                        clear_all      = 1'b1;
                        free_head_next = '0;
                        count_next     = '0;
                        found_next     = '0;
                        status_next    = ST_DONE;
                        state_next     = S_RESULT;
                    end
                    else
                    begin
                        state_next = S_HEAD;
                    end
                end
            end

            S_HEAD:
            begin
                head_next   = bucket_rd;
                cur_next    = bucket_rd;
                prev_next   = NIL_PTR;
                hit_next    = NIL_PTR;
                found_next  = '0;
                status_next = ST_DONE;
                if (bucket_rd == NIL_PTR)
                begin
                    state_next = S_ACT;
                end
                else
                begin
                    ent_raddr  = bucket_rd[IDX_W-1:0];
                    state_next = S_WALK;
                end
            end

            S_WALK:
            begin
                if (hash_q == hash_reg)
                begin
                    hit_next      = cur_reg;
                    hit_link_next = link_rd;
                    if (op_reg == OP_LOOKUP)
                    begin
                        found_next = handle_q;
                    end
                    state_next = S_ACT;
                end
                else
                begin
                    prev_next = cur_reg;
                    cur_next  = link_rd;
                    if (link_rd == NIL_PTR)
                    begin
                        state_next = S_ACT;
                    end
                    else
                    begin
                        ent_raddr = link_rd[IDX_W-1:0];
                    end
                end
            end

            S_ACT:
            begin
                state_next = S_RESULT;
                case (op_reg)
                    OP_ADD:
                    begin
                        if (hit_reg != NIL_PTR)
                        begin
                            status_next = ST_PRESENT;
                        end
                        else if (free_head_reg == NIL_PTR ||
                                 count_reg >= COUNT_W'(CAPACITY))
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            // Fetch the link of the free entry to advance the free list.
                            ent_raddr  = free_head_reg[IDX_W-1:0];
                            state_next = S_ADD_LINK;
                        end
                    end
                    OP_LOOKUP:
                    begin
                        if (hit_reg == NIL_PTR)
                        begin
                            status_next = ST_ABSENT;
                        end
                    end
                    OP_REMOVE:
                    begin
                        if (hit_reg == NIL_PTR)
                        begin
                            status_next = ST_ABSENT;
                        end
                        else
                        begin
                            // Unlink the hit from its predecessor or from the bucket.
                            if (prev_reg == NIL_PTR)
                            begin
                                bucket_we    = 1'b1;
                                bucket_wdata = hit_link_reg;
                            end
                            else
                            begin
                                link_we    = 1'b1;
                                link_waddr = prev_reg[IDX_W-1:0];
                                link_wdata = hit_link_reg;
                            end
                            state_next = S_REM_FREE;
                        end
                    end
                    default:
                    begin
                        status_next = ST_DONE;
                    end
                endcase
            end

            S_ADD_LINK:
            begin
                free_head_next = link_rd;
                link_we        = 1'b1;
                link_waddr     = free_head_reg[IDX_W-1:0];
                link_wdata     = head_reg;
                bucket_we      = 1'b1;
                bucket_wdata   = free_head_reg;
                ent_we         = 1'b1;
                count_next     = count_reg + COUNT_W'(1);
                state_next     = S_RESULT;
            end

            S_REM_FREE:
            begin
                link_we        = 1'b1;
                link_waddr     = hit_reg[IDX_W-1:0];
                link_wdata     = free_head_reg;
                free_head_next = hit_reg;
                if (count_reg != '0)
                begin
                    count_next = count_reg - COUNT_W'(1);
                end
                state_next = S_RESULT;
            end

            S_RESULT:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, m_count_reg, m_found_reg};

endmodule

/* rtl/chs_checker.sv */
// Port-level assertions for the chained hash set unit, bound to its top level.
module chs_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [chs_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [chs_pkg::STATUS_W-1:0]  m_tuser
);

    import chs_pkg::*;

    // A stalled result beat holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // The held count never exceeds the pool.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[HANDLE_BITS +: COUNT_W] <= COUNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    // A full report only comes with every entry in use.
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == ST_FULL |-> m_tdata[HANDLE_BITS +: COUNT_W] == COUNT_W'(CAPACITY))
        else $error("table full reported with free entries");

    // A handle is only returned with a done status.
    a_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != ST_DONE |-> m_tdata[HANDLE_BITS-1:0] == '0)
        else $error("handle returned on a failed operation");

    // Operations run one at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("beat accepted while an operation was in progress");

endmodule

bind chained_hash_set_unit chs_checker u_chs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
